@@ rtl/core/vtf2d_pkg.sv @@
// shared types and constants of the two-dimensional transfer function classifier
package vtf2d_pkg;

  // request kinds
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // widget field codes
  localparam logic [3:0] FS_VAL_LO   = 4'd0;
  localparam logic [3:0] FS_VAL_C    = 4'd1;
  localparam logic [3:0] FS_VAL_HI   = 4'd2;
  localparam logic [3:0] FS_GRAD_LO  = 4'd3;
  localparam logic [3:0] FS_GRAD_C   = 4'd4;
  localparam logic [3:0] FS_GRAD_HI  = 4'd5;
  localparam logic [3:0] FS_RATIO    = 4'd6;
  localparam logic [3:0] FS_OPACITY  = 4'd7;
  localparam logic [3:0] FS_RED      = 4'd8;
  localparam logic [3:0] FS_GREEN    = 4'd9;
  localparam logic [3:0] FS_BLUE     = 4'd10;
  localparam logic [3:0] FS_DIFFUSE  = 4'd11;
  localparam logic [3:0] FS_VISIBLE  = 4'd12;
  localparam logic [3:0] FS_ORDER    = 4'd13;

  // fixed point constants
  localparam logic [15:0] ONE_Q15 = 16'd32768;
  localparam logic [15:0] ONE_Q14 = 16'd16384;
  // smallest skew ratio above 0.01 in Q2.14
  localparam logic [15:0] RX_MIN  = 16'd164;
  // smallest total weight not below 0.0001 in Q1.15
  localparam int          SUM_MIN = 4;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_BAD_WRITE = 2'd1,
    ST_NO_HIT    = 2'd2
  } status_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  widget_index;
    logic [3:0]  field_select;
    logic [15:0] field_value;
    logic [15:0] sample_value;
    logic [15:0] sample_gradient;
  } vtf_in_t;

  typedef struct packed {
    logic [15:0] opacity_out;
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic [15:0] diffuse_out;
    status_t     status;
  } vtf_out_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_WR,
    S_CHK,
    S_GQ,
    S_VTENT,
    S_VQ,
    S_SKEW,
    S_RXDIV,
    S_RXQ,
    S_RXCHK,
    S_QQ,
    S_AMUL,
    S_ASH,
    S_ACC,
    S_FIN,
    S_FQ,
    S_DIV,
    S_OUT
  } fsm_t;

endpackage

@@ rtl/core/volume_transfer_function_2d_core.sv @@
// two-dimensional transfer function classifier: widget table, sequencer and shared divider
//
// channel   direction  handshake              payload
// in_       request    in_valid / in_ready    vtf_in_t  (widget write or sample)
// out_      result     out_valid / out_ready  vtf_out_t (one result per request)
// cfg_      register   cfg_wr_en              widgets_in_use (5 bits)
//
// a write request passes S_WR and S_OUT (a rejected one only S_OUT); a sample checks
// each widget in turn, where a skipped widget needs no divider run and a hit widget
// needs up to four runs of the shared radix-2 divider; the final normalizing takes
// five more divider runs, the opacity run is skipped when it saturates and all are
// skipped when the total is tiny.
// reset is synchronous: widget table reads as all zero and widgets_in_use is 0.
// a new request is taken while the previous result still waits in the output
// register; the sequencer stalls only when handing over a result.
module volume_transfer_function_2d_core
  import vtf2d_pkg::*;
#(
  parameter int MAX_WIDGETS = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  vtf_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output vtf_out_t   out_data,
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data
);

  localparam int AW  = (MAX_WIDGETS > 1) ? $clog2(MAX_WIDGETS) : 1;
  localparam int CW  = $clog2(MAX_WIDGETS + 1);
  localparam int LGM = $clog2(MAX_WIDGETS);
  localparam int SW  = 16 + LGM;
  localparam int QW  = 31 + LGM;
  localparam int MBW = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
  localparam int PW  = 16 + MBW;
  localparam int DVW = (SAMPLE_BITS > SW) ? SAMPLE_BITS : SW;
  localparam int NW0 = (PW + 1 > QW) ? PW + 1 : QW;
  localparam int XW  = ((NW0 > DVW + 15) ? NW0 : DVW + 15) + 1;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] vlo;
    logic [SAMPLE_BITS-1:0] vc;
    logic [SAMPLE_BITS-1:0] vhi;
    logic [SAMPLE_BITS-1:0] glo;
    logic [SAMPLE_BITS-1:0] gc;
    logic [SAMPLE_BITS-1:0] ghi;
    logic [15:0]            ratio;
    logic [15:0]            opac;
    logic [15:0]            red;
    logic [15:0]            green;
    logic [15:0]            blue;
    logic [15:0]            diff;
    logic                   linear;
    logic                   visible;
  } widget_t;

  // keep a ramp ordered after one of its points is written
  function automatic logic [3*SAMPLE_BITS-1:0] set_point(
    input logic [SAMPLE_BITS-1:0] lo,
    input logic [SAMPLE_BITS-1:0] c,
    input logic [SAMPLE_BITS-1:0] hi,
    input logic [1:0]             sel,
    input logic [SAMPLE_BITS-1:0] v
  );
    logic [SAMPLE_BITS-1:0] nlo, nc, nhi;
    nlo = lo;
    nc  = c;
    nhi = hi;
    case (sel)
      2'd0: begin
        nlo = v;
        if (c < v) nc = v;
        if (hi < v) nhi = v;
      end
      2'd1: begin
        nc = v;
        if (lo > v) nlo = v;
        if (hi < v) nhi = v;
      end
      default: begin
        nhi = v;
        if (c > v) nc = v;
        if (lo > v) nlo = v;
      end
    endcase
    return {nlo, nc, nhi};
  endfunction

  fsm_t state_r, state_nxt;

  // configuration
  logic [4:0] wiu_r;

  // widget table
  widget_t                mem [MAX_WIDGETS];
  logic [MAX_WIDGETS-1:0] vld_r;
  widget_t                rd_q_r;
  logic                   rd_vld_r;
  widget_t                ent;
  widget_t                wn;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic                   mem_we;

  // request and sequencing
  vtf_in_t                it_r;
  logic [AW-1:0]          addr_r;
  logic [CW-1:0]          cnt_r;
  logic [CW-1:0]          cnt_calc;
  logic [CW-1:0]          w_r;
  logic [CW-1:0]          w_inc;
  logic                   last;
  logic                   in_fire;
  logic                   wr_bad;
  logic [2:0]             k_r;
  logic [2:0]             fk_r;

  // per widget datapath
  logic [SAMPLE_BITS-1:0] val, grad;
  logic [15:0]            gv_r, av_r, rx_r, a_r;
  logic                   take;
  logic                   g_lo_side, v_lo_side;
  logic [SAMPLE_BITS-1:0] g_num, g_den, v_num, v_den;
  logic                   g_direct;
  logic [SAMPLE_BITS-1:0] span, dg;
  logic [15:0]            amin;
  logic                   rx_low, q_sat;
  logic [XW-1:0]          q_num;

  // accumulators
  logic [SW-1:0]          sum_r;
  logic [QW-1:0]          acc_r [5];
  logic                   tiny;
  logic                   op_sat;

  // shared multiplier
  logic [15:0]            mul_a;
  logic [MBW-1:0]         mul_b;
  logic [PW-1:0]          mp_r;

  // shared divider
  logic                   dv_start;
  logic [XW-1:0]          dv_num;
  logic [DVW-1:0]         dv_den;
  fsm_t                   dv_ret;
  fsm_t                   dv_ret_r;
  logic [XW-1:0]          dv_rem_r;
  logic [XW-1:0]          dv_dsh_r;
  logic [15:0]            dv_quo_r;
  logic [3:0]             dv_cnt_r;
  logic                   dv_ge;

  // result
  vtf_out_t               res_r;
  vtf_out_t               out_r;
  logic                   out_valid_r;
  logic                   out_free;

  // decode of the request and the entry under work
  assign in_fire  = in_valid && in_ready;
  assign wr_bad   = ({3'b000, in_data.widget_index} >= 7'(MAX_WIDGETS))
                    || (in_data.field_select > FS_ORDER);
  assign cnt_calc = ({2'b00, wiu_r} > 7'(MAX_WIDGETS)) ? CW'(MAX_WIDGETS) : CW'(wiu_r);
  assign w_inc    = w_r + CW'(1);
  assign last     = (w_inc == cnt_r);
  assign out_free = !out_valid_r || out_ready;
  assign ent      = rd_vld_r ? rd_q_r : '0;
  assign val      = SAMPLE_BITS'(it_r.sample_value);
  assign grad     = SAMPLE_BITS'(it_r.sample_gradient);

  // inside test and tent sides
  always_comb begin
    take = ent.visible && (ent.opac != 16'd0)
           && (val >= ent.vlo) && (val <= ent.vhi)
           && (grad >= ent.glo) && (grad <= ent.ghi);
    g_lo_side = (grad <= ent.gc);
    g_num     = g_lo_side ? grad - ent.glo : ent.ghi - grad;
    g_den     = g_lo_side ? ent.gc - ent.glo : ent.ghi - ent.gc;
    g_direct  = (g_den == '0) || (!ent.linear && (g_num != '0));
    v_lo_side = (val <= ent.vc);
    v_num     = v_lo_side ? val - ent.vlo : ent.vhi - val;
    v_den     = v_lo_side ? ent.vc - ent.vlo : ent.vhi - ent.vc;
    span      = ent.ghi - ent.glo;
    dg        = grad - ent.glo;
    amin      = (gv_r < av_r) ? gv_r : av_r;
    rx_low    = (rx_r < RX_MIN);
    q_num     = XW'(ONE_Q15 - av_r) << 14;
    q_sat     = q_num >= (XW'(rx_r) << 15);
    tiny      = (sum_r < SW'(SUM_MIN));
    op_sat    = (XW'(acc_r[0]) >= (XW'(sum_r) << 15));
  end

  // new entry for a field write
  always_comb begin
    logic [15:0]            fv;
    logic [15:0]            clip;
    logic [SAMPLE_BITS-1:0] pv;
    fv   = it_r.field_value;
    clip = (fv > ONE_Q15) ? ONE_Q15 : fv;
    pv   = SAMPLE_BITS'(fv);
    wn   = ent;
    case (it_r.field_select) inside
      [FS_VAL_LO:FS_VAL_HI]: begin
        {wn.vlo, wn.vc, wn.vhi} = set_point(ent.vlo, ent.vc, ent.vhi,
                                            2'(it_r.field_select - FS_VAL_LO), pv);
      end
      [FS_GRAD_LO:FS_GRAD_HI]: begin
        {wn.glo, wn.gc, wn.ghi} = set_point(ent.glo, ent.gc, ent.ghi,
                                            2'(it_r.field_select - FS_GRAD_LO), pv);
      end
      FS_RATIO:   wn.ratio   = clip;
      FS_OPACITY: wn.opac    = clip;
      FS_RED:     wn.red     = clip;
      FS_GREEN:   wn.green   = clip;
      FS_BLUE:    wn.blue    = clip;
      FS_DIFFUSE: wn.diff    = clip;
      FS_VISIBLE: wn.visible = (fv != 16'd0);
      default:    wn.linear  = (fv != 16'd0);
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data.kind == KIND_WRITE) begin
            state_nxt = wr_bad ? S_OUT : S_WR;
          end else begin
            state_nxt = (cnt_calc == '0) ? S_FIN : S_CHK;
          end
        end
      end
      S_WR: state_nxt = S_OUT;
      S_CHK: begin
        if (!take) begin
          state_nxt = last ? S_FIN : S_CHK;
        end else begin
          state_nxt = g_direct ? S_VTENT : S_DIV;
        end
      end
      S_GQ:    state_nxt = S_VTENT;
      S_VTENT: state_nxt = (v_den == '0) ? S_SKEW : S_DIV;
      S_VQ:    state_nxt = S_SKEW;
      S_SKEW: begin
        if (ent.ratio == ONE_Q14) begin
          state_nxt = S_AMUL;
        end else if (span == '0) begin
          state_nxt = S_RXCHK;
        end else begin
          state_nxt = S_RXDIV;
        end
      end
      S_RXDIV: state_nxt = S_DIV;
      S_RXQ:   state_nxt = S_RXCHK;
      S_RXCHK: state_nxt = (rx_low || q_sat) ? S_AMUL : S_DIV;
      S_QQ:    state_nxt = S_AMUL;
      S_AMUL:  state_nxt = S_ASH;
      S_ASH:   state_nxt = S_ACC;
      S_ACC: begin
        if (k_r == 3'd5) begin
          state_nxt = last ? S_FIN : S_CHK;
        end
      end
      S_FIN: begin
        if (tiny) begin
          state_nxt = S_OUT;
        end else if ((fk_r == 3'd0) && op_sat) begin
          state_nxt = S_FQ;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_FQ:  state_nxt = (fk_r == 3'd4) ? S_OUT : S_FIN;
      S_DIV: state_nxt = (dv_cnt_r == 4'd15) ? dv_ret_r : S_DIV;
      S_OUT: state_nxt = out_free ? S_IDLE : S_OUT;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = '0;
    mem_we   = 1'b0;
    dv_start = 1'b0;
    dv_num   = '0;
    dv_den   = '0;
    dv_ret   = S_IDLE;
    mul_a    = '0;
    mul_b    = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          if (in_data.kind == KIND_WRITE) begin
            rd_en   = !wr_bad;
            rd_addr = AW'(in_data.widget_index);
          end else begin
            rd_en   = (cnt_calc != '0);
          end
        end
      end
      S_WR: mem_we = 1'b1;
      S_CHK: begin
        if (!take) begin
          rd_en   = !last;
          rd_addr = w_inc[AW-1:0];
        end else if (!g_direct) begin
          dv_start = 1'b1;
          dv_num   = XW'(g_num) << 15;
          dv_den   = DVW'(g_den);
          dv_ret   = S_GQ;
        end
      end
      S_VTENT: begin
        if (v_den != '0) begin
          dv_start = 1'b1;
          dv_num   = XW'(v_num) << 15;
          dv_den   = DVW'(v_den);
          dv_ret   = S_VQ;
        end
      end
      S_SKEW: begin
        mul_a = ent.ratio;
        mul_b = MBW'(span - dg);
      end
      S_RXDIV: begin
        dv_start = 1'b1;
        dv_num   = XW'(mp_r) + (XW'(dg) << 14);
        dv_den   = DVW'(span);
        dv_ret   = S_RXQ;
      end
      S_RXCHK: begin
        if (!(rx_low || q_sat)) begin
          dv_start = 1'b1;
          dv_num   = q_num;
          dv_den   = DVW'(rx_r);
          dv_ret   = S_QQ;
        end
      end
      S_AMUL: begin
        mul_a = amin;
        mul_b = MBW'(ent.opac);
      end
      S_ACC: begin
        mul_a = a_r;
        case (k_r)
          3'd0:    mul_b = MBW'(a_r);
          3'd1:    mul_b = MBW'(ent.red);
          3'd2:    mul_b = MBW'(ent.green);
          3'd3:    mul_b = MBW'(ent.blue);
          default: mul_b = MBW'(ent.diff);
        endcase
        if (k_r == 3'd5) begin
          rd_en   = !last;
          rd_addr = w_inc[AW-1:0];
        end
      end
      S_FIN: begin
        if (!tiny && !((fk_r == 3'd0) && op_sat)) begin
          dv_start = 1'b1;
          dv_num   = XW'(acc_r[fk_r]);
          dv_den   = DVW'(sum_r);
          dv_ret   = S_FQ;
        end
      end
      default: begin
      end
    endcase
  end

  // state register and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wiu_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) wiu_r <= cfg_wr_data;
    end
  end

  // widget table memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[addr_r] <= wn;
    if (rd_en) rd_q_r <= mem[rd_addr];
  end

  // entry valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (mem_we) vld_r[addr_r] <= 1'b1;
      if (rd_en) rd_vld_r <= vld_r[rd_addr];
    end
  end

  // shared multiplier, registered
  always_ff @(posedge clk) begin
    mp_r <= PW'(mul_a) * PW'(mul_b);
  end

  // shared divider, one quotient bit a cycle
  assign dv_ge = (dv_rem_r >= dv_dsh_r);

  always_ff @(posedge clk) begin
    if (dv_start) begin
      dv_rem_r <= dv_num;
      dv_dsh_r <= XW'(dv_den) << 15;
      dv_cnt_r <= '0;
      dv_ret_r <= dv_ret;
    end else if (state_r == S_DIV) begin
      if (dv_ge) dv_rem_r <= dv_rem_r - dv_dsh_r;
      dv_quo_r <= {dv_quo_r[14:0], dv_ge};
      dv_dsh_r <= dv_dsh_r >> 1;
      dv_cnt_r <= dv_cnt_r + 4'd1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          it_r   <= in_data;
          addr_r <= AW'(in_data.widget_index);
          cnt_r  <= cnt_calc;
          w_r    <= '0;
          sum_r  <= '0;
          fk_r   <= '0;
          for (int i = 0; i < 5; i++) acc_r[i] <= '0;
          res_r  <= '{opacity_out: 16'd0, red_out: 16'd0, green_out: 16'd0,
                      blue_out: 16'd0, diffuse_out: 16'd0,
                      status: ((in_data.kind == KIND_WRITE) && wr_bad) ?
                              ST_BAD_WRITE : ST_DONE};
        end
      end
      S_CHK: begin
        if (!take) begin
          w_r <= w_inc;
        end else if (g_direct) begin
          gv_r <= ONE_Q15;
        end
      end
      S_GQ: gv_r <= dv_quo_r;
      S_VTENT: begin
        if (v_den == '0) av_r <= ONE_Q15;
      end
      S_VQ: av_r <= dv_quo_r;
      S_SKEW: begin
        if (span == '0) rx_r <= ent.ratio;
      end
      S_RXQ: rx_r <= dv_quo_r;
      S_RXCHK: begin
        if (rx_low || q_sat) av_r <= '0;
      end
      S_QQ: av_r <= ONE_Q15 - dv_quo_r;
      S_ASH: begin
        a_r   <= mp_r[30:15];
        sum_r <= sum_r + SW'(mp_r[30:15]);
        k_r   <= '0;
      end
      S_ACC: begin
        if (k_r != 3'd0) acc_r[k_r - 3'd1] <= acc_r[k_r - 3'd1] + QW'(mp_r);
        if (k_r == 3'd5) begin
          w_r <= w_inc;
        end else begin
          k_r <= k_r + 3'd1;
        end
      end
      S_FIN: begin
        if (tiny) res_r.status <= ST_NO_HIT;
      end
      S_FQ: begin
        case (fk_r)
          3'd0:    res_r.opacity_out <= op_sat ? ONE_Q15 : dv_quo_r;
          3'd1:    res_r.red_out     <= dv_quo_r;
          3'd2:    res_r.green_out   <= dv_quo_r;
          3'd3:    res_r.blue_out    <= dv_quo_r;
          default: res_r.diffuse_out <= dv_quo_r;
        endcase
        fk_r <= fk_r + 3'd1;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_OUT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_OUT) && out_free) out_r <= res_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ verif/tb_volume_transfer_function_2d_core.sv @@
// self-checking testbench for the two-dimensional transfer function classifier core
`timescale 1ns / 1ps

module tb_volume_transfer_function_2d_core;
  import vtf2d_pkg::*;

  localparam int NW = 16;
  localparam int SETTLE_CYCLES = 1500;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  vtf_in_t    in_data;
  logic       out_valid;
  logic       out_ready;
  vtf_out_t   out_data;
  logic       cfg_wr_en;
  logic [4:0] cfg_wr_data;

  volume_transfer_function_2d_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // shadow widget table
  logic [15:0] vr [NW][3];
  logic [15:0] gr [NW][3];
  logic [15:0] ratio_tab [NW];
  logic [15:0] opac_tab [NW];
  logic [15:0] col_tab [NW][3];
  logic [15:0] diff_tab [NW];
  logic        vis_tab [NW];
  logic        lin_tab [NW];
  logic [4:0]  active_count;

  vtf_in_t  request_queue [$];
  vtf_out_t classified_queue [$];
  int  errors;
  int  results_seen;
  int  hits_seen;
  bit  in_taken;
  bit  quiet_rx;
  bit  hold_rx;
  bit  quiet_tx;

  always #10 clk = ~clk;

  // ramp point write keeping lo <= centre <= hi
  function automatic void place_point(ref logic [15:0] r [3], input int sel,
                                      input logic [15:0] v);
    r[sel] = v;
    if (sel == 0) begin
      if (r[1] < v) r[1] = v;
      if (r[2] < v) r[2] = v;
    end else if (sel == 1) begin
      if (r[0] > v) r[0] = v;
      if (r[2] < v) r[2] = v;
    end else begin
      if (r[1] > v) r[1] = v;
      if (r[0] > v) r[0] = v;
    end
  endfunction

  function automatic logic [15:0] clip_frac(logic [15:0] v);
    return (v > ONE_Q15) ? ONE_Q15 : v;
  endfunction

  // tent level in Q1.15; above_zero set when the numerator is positive or the side has zero width
  function automatic longint tent_level(longint x, longint lo, longint c, longint hi,
                                        output bit above_zero);
    longint num, den;
    if (x <= c) begin
      num = x - lo;
      den = c - lo;
    end else begin
      num = hi - x;
      den = hi - c;
    end
    if (den == 0) begin
      above_zero = 1;
      return ONE_Q15;
    end
    above_zero = (num > 0);
    return (num << 15) / den;
  endfunction

  function automatic longint widget_level(int w, longint v, longint g);
    bit pos;
    longint gv, av, span, dg, rx, q;
    gv = tent_level(g, gr[w][0], gr[w][1], gr[w][2], pos);
    if (!lin_tab[w] && pos) gv = ONE_Q15;
    av = tent_level(v, vr[w][0], vr[w][1], vr[w][2], pos);
    if (ratio_tab[w] != ONE_Q14) begin
      span = gr[w][2] - gr[w][0];
      if (span == 0) rx = ratio_tab[w];
      else begin
        dg = g - gr[w][0];
        if (dg > span) dg = span;
        rx = (ratio_tab[w] * (span - dg) + ONE_Q14 * dg) / span;
      end
      if (rx * 100 > ONE_Q14) begin
        q = ((ONE_Q15 - av) * ONE_Q14) / rx;
        av = (q >= ONE_Q15) ? 0 : ONE_Q15 - q;
      end else av = 0;
    end
    return (gv < av) ? gv : av;
  endfunction

  // compute the expected result of a request and update the shadow table
  function automatic vtf_out_t classify_request(vtf_in_t rq);
    vtf_out_t r;
    int w, cnt;
    longint a, sum, sq, cr, cg, cb, cd, op;
    r = '0;
    r.status = ST_DONE;
    if (rq.kind == KIND_WRITE) begin
      w = rq.widget_index;
      if (rq.field_select > FS_ORDER) begin
        r.status = ST_BAD_WRITE;
        return r;
      end
      case (rq.field_select)
        FS_RATIO:   ratio_tab[w] = clip_frac(rq.field_value);
        FS_OPACITY: opac_tab[w] = clip_frac(rq.field_value);
        FS_RED:     col_tab[w][0] = clip_frac(rq.field_value);
        FS_GREEN:   col_tab[w][1] = clip_frac(rq.field_value);
        FS_BLUE:    col_tab[w][2] = clip_frac(rq.field_value);
        FS_DIFFUSE: diff_tab[w] = clip_frac(rq.field_value);
        FS_VISIBLE: vis_tab[w] = (rq.field_value != 0);
        FS_ORDER:   lin_tab[w] = (rq.field_value != 0);
        default: begin
          if (rq.field_select <= FS_VAL_HI)
            place_point(vr[w], rq.field_select - FS_VAL_LO, rq.field_value);
          else
            place_point(gr[w], rq.field_select - FS_GRAD_LO, rq.field_value);
        end
      endcase
      return r;
    end
    cnt = (active_count > NW) ? NW : active_count;
    sum = 0; sq = 0; cr = 0; cg = 0; cb = 0; cd = 0;
    for (w = 0; w < cnt; w++) begin
      if (!vis_tab[w] || opac_tab[w] == 0) continue;
      if (rq.sample_value < vr[w][0] || rq.sample_value > vr[w][2]) continue;
      if (rq.sample_gradient < gr[w][0] || rq.sample_gradient > gr[w][2]) continue;
      a = (widget_level(w, rq.sample_value, rq.sample_gradient) * opac_tab[w]) >> 15;
      sum += a;
      sq += a * a;
      cr += a * col_tab[w][0];
      cg += a * col_tab[w][1];
      cb += a * col_tab[w][2];
      cd += a * diff_tab[w];
    end
    if (sum * 10000 < ONE_Q15) begin
      r.status = ST_NO_HIT;
      return r;
    end
    op = sq / sum;
    r.opacity_out = (op > ONE_Q15) ? ONE_Q15 : op[15:0];
    r.red_out = 16'(cr / sum);
    r.green_out = 16'(cg / sum);
    r.blue_out = 16'(cb / sum);
    r.diffuse_out = 16'(cd / sum);
    return r;
  endfunction

  // request driver, changes inputs on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (request_queue.size() != 0 && !quiet_tx && (hold_rx || $urandom_range(99) >= 10)) begin
        in_valid <= 1'b1;
        in_data <= request_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // request acceptance produces the expected result
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && in_ready;
    if (in_taken)
      classified_queue.push_back(classify_request(in_data));
  end

  // result receiver stalls
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !hold_rx && (quiet_rx || $urandom_range(99) >= 10);
  end

  // result checker
  always @(posedge clk) begin
    vtf_out_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (classified_queue.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = classified_queue.pop_front();
        if (out_data.status == ST_DONE && out_data.opacity_out != 0) hits_seen++;
        if (out_data.opacity_out !== e.opacity_out) begin
          $error("opacity_out exp %0d got %0d", e.opacity_out, out_data.opacity_out);
          errors++;
        end
        if (out_data.red_out !== e.red_out) begin
          $error("red_out exp %0d got %0d", e.red_out, out_data.red_out);
          errors++;
        end
        if (out_data.green_out !== e.green_out) begin
          $error("green_out exp %0d got %0d", e.green_out, out_data.green_out);
          errors++;
        end
        if (out_data.blue_out !== e.blue_out) begin
          $error("blue_out exp %0d got %0d", e.blue_out, out_data.blue_out);
          errors++;
        end
        if (out_data.diffuse_out !== e.diffuse_out) begin
          $error("diffuse_out exp %0d got %0d", e.diffuse_out, out_data.diffuse_out);
          errors++;
        end
        if (out_data.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_data.status);
          errors++;
        end
      end
    end
  end

  function automatic vtf_in_t wr_req(int w, logic [3:0] fs, logic [15:0] v);
    vtf_in_t r;
    r = '0;
    r.kind = KIND_WRITE;
    r.widget_index = w[3:0];
    r.field_select = fs;
    r.field_value = v;
    r.sample_value = 16'($urandom);
    r.sample_gradient = 16'($urandom);
    return r;
  endfunction

  function automatic vtf_in_t sample_req(logic [15:0] v, logic [15:0] g);
    vtf_in_t r;
    r = '0;
    r.kind = KIND_SAMPLE;
    r.widget_index = 4'($urandom);
    r.field_select = 4'($urandom);
    r.field_value = 16'($urandom);
    r.sample_value = v;
    r.sample_gradient = g;
    return r;
  endfunction

  // wait until every request is accepted and answered, then let the block settle
  task automatic drain();
    wait (request_queue.size() == 0 && !in_valid && classified_queue.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_active(logic [4:0] n);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= n;
    active_count = n;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // random widget with a well-formed shape
  task automatic build_widget(int w);
    int a, b;
    a = $urandom_range(40000);
    b = a + $urandom_range(25000);
    request_queue.push_back(wr_req(w, FS_VAL_LO, 16'(a)));
    request_queue.push_back(wr_req(w, FS_VAL_HI, 16'(b)));
    request_queue.push_back(wr_req(w, FS_VAL_C, 16'($urandom_range(a, b))));
    a = $urandom_range(40000);
    b = a + (($urandom_range(9) == 0) ? 0 : $urandom_range(25000));
    request_queue.push_back(wr_req(w, FS_GRAD_LO, 16'(a)));
    request_queue.push_back(wr_req(w, FS_GRAD_HI, 16'(b)));
    request_queue.push_back(wr_req(w, FS_GRAD_C, 16'($urandom_range(a, b))));
    request_queue.push_back(wr_req(w, FS_RATIO,
      ($urandom_range(2) == 0) ? ONE_Q14 : 16'($urandom_range(40000))));
    request_queue.push_back(wr_req(w, FS_OPACITY, 16'($urandom_range(36000))));
    request_queue.push_back(wr_req(w, FS_RED, 16'($urandom)));
    request_queue.push_back(wr_req(w, FS_GREEN, 16'($urandom_range(32768))));
    request_queue.push_back(wr_req(w, FS_BLUE, 16'($urandom_range(32768))));
    request_queue.push_back(wr_req(w, FS_DIFFUSE, 16'($urandom)));
    request_queue.push_back(wr_req(w, FS_VISIBLE, 16'($urandom_range(4) != 0)));
    request_queue.push_back(wr_req(w, FS_ORDER, 16'($urandom_range(1))));
  endtask

  // sample mostly inside some widget
  function automatic vtf_in_t aimed_sample();
    int w;
    w = $urandom_range(NW - 1);
    if ($urandom_range(5) == 0) return sample_req(16'($urandom), 16'($urandom));
    return sample_req(16'($urandom_range(vr[w][0], vr[w][2])),
                      16'($urandom_range(gr[w][0], gr[w][2])));
  endfunction

  initial begin
    int n, k;
    vtf_in_t rq;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    errors = 0;
    results_seen = 0;
    hits_seen = 0;
    in_taken = 0;
    quiet_rx = 0;
    hold_rx = 0;
    quiet_tx = 0;
    active_count = '0;
    for (int w = 0; w < NW; w++) begin
      vr[w] = '{default: '0};
      gr[w] = '{default: '0};
      col_tab[w] = '{default: '0};
      ratio_tab[w] = '0;
      opac_tab[w] = '0;
      diff_tab[w] = '0;
      vis_tab[w] = 0;
      lin_tab[w] = 0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty table, bad fields, clipping, extremes, zero-width sides
    request_queue.push_back(sample_req(16'h0000, 16'h0000));
    request_queue.push_back(wr_req(0, 4'd14, 16'hFFFF));
    request_queue.push_back(wr_req(15, 4'd15, 16'h1234));
    request_queue.push_back(wr_req(0, FS_VAL_HI, 16'hFFFF));
    request_queue.push_back(wr_req(0, FS_VAL_C, 16'h8000));
    request_queue.push_back(wr_req(0, FS_GRAD_HI, 16'hFFFF));
    request_queue.push_back(wr_req(0, FS_OPACITY, 16'hFFFF));
    request_queue.push_back(wr_req(0, FS_RED, 16'hFFFF));
    request_queue.push_back(wr_req(0, FS_GREEN, 16'h4000));
    request_queue.push_back(wr_req(0, FS_BLUE, 16'h0001));
    request_queue.push_back(wr_req(0, FS_DIFFUSE, 16'h8001));
    request_queue.push_back(wr_req(0, FS_RATIO, 16'hFFFF));
    request_queue.push_back(wr_req(0, FS_VISIBLE, 16'h0100));
    request_queue.push_back(wr_req(15, FS_VAL_LO, 16'h5000));
    request_queue.push_back(wr_req(15, FS_VAL_HI, 16'h5000));
    request_queue.push_back(wr_req(15, FS_GRAD_LO, 16'h7000));
    request_queue.push_back(wr_req(15, FS_OPACITY, 16'h8000));
    request_queue.push_back(wr_req(15, FS_RATIO, 16'd100));
    request_queue.push_back(wr_req(15, FS_VISIBLE, 16'h0001));
    drain();
    set_active(5'd16);
    request_queue.push_back(sample_req(16'h8000, 16'h0000));
    request_queue.push_back(sample_req(16'hFFFF, 16'hFFFF));
    request_queue.push_back(sample_req(16'h5000, 16'h7000));
    request_queue.push_back(wr_req(15, FS_RATIO, ONE_Q14));
    request_queue.push_back(wr_req(0, FS_ORDER, 16'h0001));
    request_queue.push_back(sample_req(16'h5000, 16'h7000));
    request_queue.push_back(sample_req(16'h4000, 16'h2000));
    drain();

    // random phases: build widgets, classify, vary active count and pressure
    for (int ph = 0; ph < 8; ph++) begin
      quiet_rx = (ph == 2);
      set_active((ph == 0) ? 5'd0 : (ph == 1) ? 5'd31 : (ph == 7) ? 5'd16 :
                 5'($urandom_range(1, 20)));
      n = 1 + $urandom_range(3);
      for (int j = 0; j < n; j++) build_widget($urandom_range(NW - 1));
      for (int j = 0; j < 200; j++) begin
        k = $urandom_range(99);
        if (k < 75) rq = aimed_sample();
        else if (k < 95) rq = wr_req($urandom_range(NW - 1), 4'($urandom_range(13)),
                                     16'($urandom));
        else rq = wr_req($urandom_range(NW - 1), 4'($urandom_range(14, 15)), 16'($urandom));
        request_queue.push_back(rq);
      end
      if (ph == 4) begin
        // long receiver hold-off while requests keep coming
        hold_rx = 1;
        repeat (3000) @(posedge clk);
        hold_rx = 0;
      end
      if (ph == 5) begin
        // sender pauses until every result has come back
        wait (request_queue.size() < 100);
        quiet_tx = 1;
        wait (classified_queue.size() == 0);
        repeat (20) @(posedge clk);
        quiet_tx = 0;
      end
      drain();
    end
    $display("covered %0d results, %0d with nonzero opacity, over several widget counts",
             results_seen, hits_seen);
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // overall time limit
  initial begin
    #400ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
